// ===== src/stack_machine_core_assert.svh =====
// Assertion macros for the stack machine core.
// Each use names the clock and the active-low reset as clk and rst_n.
`ifndef STACK_MACHINE_CORE_ASSERT_SVH
`define STACK_MACHINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define SMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SMC_ASSERT(lbl, prop, msg)

`define SMC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/smc_pkg.sv =====
package smc_pkg;

    localparam int STACK_DEPTH   = 128;
    localparam int VAR_DEPTH     = 128;
    localparam int PROGRAM_DEPTH = 4096;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 13;
    localparam int SI_W   = $clog2(STACK_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int VI_W   = (VAR_DEPTH > 1) ? $clog2(VAR_DEPTH) : 1;

    typedef enum logic [4:0] {
        OP_PUSH  = 5'd0,
        OP_POP   = 5'd1,
        OP_ADD   = 5'd2,
        OP_SUB   = 5'd3,
        OP_MUL   = 5'd4,
        OP_DIV   = 5'd5,
        OP_DUP   = 5'd6,
        OP_SWAP  = 5'd7,
        OP_PRINT = 5'd8,
        OP_JMP   = 5'd9,
        OP_JZ    = 5'd10,
        OP_JNZ   = 5'd11,
        OP_EQ    = 5'd12,
        OP_LT    = 5'd13,
        OP_GT    = 5'd14,
        OP_ALLOC = 5'd15,
        OP_LOAD  = 5'd16,
        OP_STORE = 5'd17,
        OP_HALT  = 5'd18
    } op_t;

    typedef enum logic [2:0] {
        ST_RUN   = 3'd0,
        ST_END   = 3'd1,
        ST_BADOP = 3'd2,
        ST_STACK = 3'd3,
        ST_DIV0  = 3'd4,
        ST_INDEX = 3'd5
    } status_t;

endpackage

// ===== src/smc_ram.sv =====
module smc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/smc_div.sv =====
module smc_div
    import smc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DATA_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        if (!rem_sub[DATA_W])
        begin
            rem_next = rem_sub[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_W);
                rem_reg  <= '0;
                quo_reg  <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
                dvs_reg  <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
                neg_reg  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ===== src/stack_machine_core.sv =====
// Flow: a command is taken in S_IDLE; the top and second stack words are captured in
//   S_TOP and S_SEC; S_EXEC computes and commits (div waits in S_DIV for the 32-step
//   serial divider, swap writes its second word in S_SWAP); S_DONE loads the result
//   registers once the output is free. Only one instruction is in flight at a time.
// Reset: stack pointer, address, stop flag and variable valid bits clear at once;
//   no clearing pass, commands are taken right after reset.
`include "stack_machine_core_assert.svh"

module stack_machine_core
    import smc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [ADDR_W-1:0]        cfg_data,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  logic [4:0]               opcode,
    input  logic signed [DATA_W-1:0] immediate,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [ADDR_W-1:0]        next_address,
    output logic                     print_valid,
    output logic signed [DATA_W-1:0] print_value,
    output logic [2:0]               status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOP,
        S_SEC,
        S_EXEC,
        S_DIV,
        S_SWAP,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [4:0]        op_reg;
    logic [DATA_W-1:0] imm_reg;
    logic [DATA_W-1:0] top_reg;
    logic [DATA_W-1:0] sec_reg;
    logic [DATA_W-1:0] var_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [ADDR_W-1:0] ip_reg;
    logic              stopped_reg;
    status_t           cause_reg;
    logic [ADDR_W-1:0] plen_reg;
    logic [VAR_DEPTH-1:0] var_valid_reg;

    logic [ADDR_W-1:0] pend_addr_reg;
    logic              pend_pv_reg;
    logic [DATA_W-1:0] pend_pval_reg;
    status_t           pend_status_reg;

    logic              res_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_pv_reg;
    logic [DATA_W-1:0] out_pval_reg;
    status_t           out_status_reg;

    logic [SI_W-1:0]   stk_raddr, stk_waddr;
    logic [DATA_W-1:0] stk_rdata, stk_wdata;
    logic              stk_we;
    logic [VI_W-1:0]   var_raddr, var_idx;
    logic [DATA_W-1:0] var_rdata, var_wdata;
    logic              var_we;

    logic              div_start, div_busy, div_done;
    logic [DATA_W-1:0] div_q;

    logic [ADDR_W-1:0] len;
    logic              at_end;
    status_t           fault;
    logic [ADDR_W:0]   nxt;
    logic [SP_W-1:0]   sp_n;
    logic              c_stk_we, c_var_we, need_div, pv;
    logic [SI_W-1:0]   c_stk_waddr;
    logic [DATA_W-1:0] c_stk_wdata, c_var_wdata, r_mul;
    logic              imm_bad_tgt, imm_bad_var;
    logic              do_commit;
    logic [ADDR_W-1:0] fin_addr;
    status_t           fin_status;
    logic              fin_stop;
    logic              out_free;
    logic [SP_W-1:0]   sp_m1, sp_m2;

    assign sp_m1 = sp_reg - 1'b1;
    assign sp_m2 = sp_reg - SP_W'(2);
    assign var_idx = imm_reg[VI_W-1:0];
    assign len = (plen_reg > ADDR_W'(PROGRAM_DEPTH)) ? ADDR_W'(PROGRAM_DEPTH) : plen_reg;
    assign at_end = ip_reg >= len;
    assign imm_bad_tgt = imm_reg > {{(DATA_W-ADDR_W){1'b0}}, len};
    assign imm_bad_var = imm_reg >= DATA_W'(VAR_DEPTH);
    assign r_mul = top_reg * sec_reg;

    always_comb
    begin
        fault       = ST_RUN;
        nxt         = {1'b0, ip_reg} + 1'b1;
        sp_n        = sp_reg;
        c_stk_we    = 1'b0;
        c_stk_waddr = sp_reg[SI_W-1:0];
        c_stk_wdata = imm_reg;
        c_var_we    = 1'b0;
        c_var_wdata = '0;
        need_div    = 1'b0;
        pv          = 1'b0;
        case (op_reg)
            OP_PUSH:
            begin
                if (sp_reg >= SP_W'(STACK_DEPTH))
                    fault = ST_STACK;
                else
                begin
                    c_stk_we = 1'b1;
                    sp_n     = sp_reg + 1'b1;
                    nxt      = {1'b0, ip_reg} + (ADDR_W+1)'(2);
                end
            end
            OP_POP:
            begin
                if (sp_reg < SP_W'(1))
                    fault = ST_STACK;
                else
                    sp_n = sp_m1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_GT:
            begin
                c_stk_waddr = sp_m2[SI_W-1:0];
                case (op_reg)
                    OP_ADD:  c_stk_wdata = sec_reg + top_reg;
                    OP_SUB:  c_stk_wdata = sec_reg - top_reg;
                    OP_MUL:  c_stk_wdata = r_mul;
                    OP_DIV:  c_stk_wdata = div_q;
                    OP_EQ:   c_stk_wdata = DATA_W'(sec_reg == top_reg);
                    OP_LT:   c_stk_wdata = DATA_W'($signed(sec_reg) < $signed(top_reg));
                    default: c_stk_wdata = DATA_W'($signed(sec_reg) > $signed(top_reg));
                endcase
                if (sp_reg < SP_W'(2))
                    fault = ST_STACK;
                else if (op_reg == OP_DIV && top_reg == '0)
                    fault = ST_DIV0;
                else
                begin
                    c_stk_we = 1'b1;
                    sp_n     = sp_m1;
                    need_div = (op_reg == OP_DIV);
                end
            end
            OP_DUP:
            begin
                c_stk_wdata = top_reg;
                if (sp_reg < SP_W'(1) || sp_reg >= SP_W'(STACK_DEPTH))
                    fault = ST_STACK;
                else
                begin
                    c_stk_we = 1'b1;
                    sp_n     = sp_reg + 1'b1;
                end
            end
            OP_SWAP:
            begin
                c_stk_waddr = sp_m1[SI_W-1:0];
                c_stk_wdata = sec_reg;
                if (sp_reg < SP_W'(2))
                    fault = ST_STACK;
                else
                    c_stk_we = 1'b1;
            end
            OP_PRINT:
            begin
                if (sp_reg < SP_W'(1))
                    fault = ST_STACK;
                else
                    pv = 1'b1;
            end
            OP_JMP:
            begin
                if (imm_bad_tgt)
                    fault = ST_INDEX;
                else
                    nxt = imm_reg[ADDR_W:0];
            end
            OP_JZ, OP_JNZ:
            begin
                if (sp_reg < SP_W'(1))
                    fault = ST_STACK;
                else if ((top_reg == '0) == (op_reg == OP_JZ))
                begin
                    if (imm_bad_tgt)
                        fault = ST_INDEX;
                    else
                    begin
                        nxt  = imm_reg[ADDR_W:0];
                        sp_n = sp_m1;
                    end
                end
                else
                begin
                    nxt  = {1'b0, ip_reg} + (ADDR_W+1)'(2);
                    sp_n = sp_m1;
                end
            end
            OP_ALLOC:
            begin
                if (imm_bad_var)
                    fault = ST_INDEX;
                else
                begin
                    c_var_we = 1'b1;
                    nxt      = {1'b0, ip_reg} + (ADDR_W+1)'(2);
                end
            end
            OP_LOAD:
            begin
                c_stk_wdata = var_reg;
                if (imm_bad_var)
                    fault = ST_INDEX;
                else if (sp_reg >= SP_W'(STACK_DEPTH))
                    fault = ST_STACK;
                else
                begin
                    c_stk_we = 1'b1;
                    sp_n     = sp_reg + 1'b1;
                    nxt      = {1'b0, ip_reg} + (ADDR_W+1)'(2);
                end
            end
            OP_STORE:
            begin
                c_var_wdata = top_reg;
                if (imm_bad_var)
                    fault = ST_INDEX;
                else if (sp_reg < SP_W'(1))
                    fault = ST_STACK;
                else
                begin
                    c_var_we = 1'b1;
                    sp_n     = sp_m1;
                    nxt      = {1'b0, ip_reg} + (ADDR_W+1)'(2);
                end
            end
            OP_HALT:
                fault = ST_END;
            default:
                fault = ST_BADOP;
        endcase
    end

    always_comb
    begin
        fin_stop   = 1'b0;
        fin_addr   = ip_reg;
        fin_status = ST_RUN;
        if (stopped_reg)
            fin_status = cause_reg;
        else if (at_end)
        begin
            fin_stop   = 1'b1;
            fin_addr   = len;
            fin_status = ST_END;
        end
        else if (fault != ST_RUN)
        begin
            fin_stop   = 1'b1;
            fin_status = fault;
        end
        else if (nxt >= {1'b0, len})
        begin
            fin_stop   = 1'b1;
            fin_addr   = len;
            fin_status = ST_END;
        end
        else
            fin_addr = nxt[ADDR_W-1:0];
    end

    assign do_commit = (state_reg == S_EXEC && !(need_div && !stopped_reg && !at_end))
                    || (state_reg == S_DIV && div_done);
    wire normal_run = !stopped_reg && !at_end && fault == ST_RUN;

    assign div_start = state_reg == S_EXEC && normal_run && need_div;
    assign out_free  = !res_valid_reg || !res_stall;

    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = c_stk_waddr;
        stk_wdata = c_stk_wdata;
        if (state_reg == S_SWAP)
        begin
            stk_we    = 1'b1;
            stk_waddr = sp_m2[SI_W-1:0];
            stk_wdata = top_reg;
        end
        else if (do_commit && normal_run)
            stk_we = c_stk_we;
    end

    assign var_we    = do_commit && normal_run && c_var_we;
    assign var_wdata = c_var_wdata;
    assign stk_raddr = (state_reg == S_TOP) ? sp_m2[SI_W-1:0] : sp_m1[SI_W-1:0];
    assign var_raddr = (state_reg == S_IDLE) ? immediate[VI_W-1:0] : var_idx;

    smc_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    smc_ram #(.WIDTH(DATA_W), .DEPTH(VAR_DEPTH)) u_var_ram (
        .clk   (clk),
        .we    (var_we),
        .waddr (var_idx),
        .wdata (var_wdata),
        .raddr (var_raddr),
        .rdata (var_rdata)
    );

    smc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sec_reg),
        .divisor  (top_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            ip_reg        <= '0;
            stopped_reg   <= 1'b0;
            cause_reg     <= ST_RUN;
            plen_reg      <= '0;
            var_valid_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                plen_reg <= cfg_data;
            if (state_reg == S_DONE && out_free)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && !res_stall)
                res_valid_reg <= 1'b0;
            if (var_we)
                var_valid_reg[var_idx] <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        op_reg    <= opcode;
                        imm_reg   <= immediate;
                        state_reg <= S_TOP;
                    end
                end
                S_TOP:
                begin
                    top_reg   <= stk_rdata;
                    var_reg   <= var_valid_reg[var_idx] ? var_rdata : '0;
                    state_reg <= S_SEC;
                end
                S_SEC:
                begin
                    sec_reg   <= stk_rdata;
                    state_reg <= S_EXEC;
                end
                S_EXEC, S_DIV:
                begin
                    if (do_commit)
                    begin
                        pend_addr_reg   <= fin_addr;
                        pend_status_reg <= fin_status;
                        pend_pv_reg     <= normal_run && pv;
                        pend_pval_reg   <= (normal_run && pv) ? top_reg : '0;
                        if (!stopped_reg)
                        begin
                            ip_reg <= fin_addr;
                            if (fin_stop)
                            begin
                                stopped_reg <= 1'b1;
                                cause_reg   <= fin_status;
                            end
                            if (normal_run)
                                sp_reg <= sp_n;
                        end
                        state_reg <= (normal_run && op_reg == OP_SWAP) ? S_SWAP : S_DONE;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_SWAP:
                    state_reg <= S_DONE;
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_addr_reg   <= pend_addr_reg;
                        out_pv_reg     <= pend_pv_reg;
                        out_pval_reg   <= pend_pval_reg;
                        out_status_reg <= pend_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign cmd_stall    = state_reg != S_IDLE;
    assign res_valid    = res_valid_reg;
    assign next_address = out_addr_reg;
    assign print_valid  = out_pv_reg;
    assign print_value  = out_pval_reg;
    assign status       = out_status_reg;

    `SMC_ASSERT(a_sp_bound, sp_reg <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
    `SMC_ASSERT_NEXT(a_stop_sticky, stopped_reg, stopped_reg, "stop flag cleared without reset")
    `SMC_ASSERT(a_stop_cause, !stopped_reg || cause_reg != ST_RUN, "stopped with run cause")
    `SMC_ASSERT(a_div_state, !div_busy || state_reg == S_DIV, "divider busy outside divide wait")

endmodule

// ===== dv/stack_machine_core_tb.sv =====
`timescale 1ns / 1ps

module stack_machine_core_tb;
    import smc_pkg::*;

    localparam int ITEMS = 1150;
    localparam int LIMIT = 900000;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              pv;
        logic [31:0]       val;
        logic [2:0]        st;
    } smc_result_t;

    class smc_scoreboard;
        bit [31:0]     stk[STACK_DEPTH];
        bit [31:0]     vars[VAR_DEPTH];
        int unsigned   sp;
        int unsigned   ip;
        bit            stopped;
        bit [2:0]      cause;
        int unsigned   prog_len;
        smc_result_t   pending[$];
        int            errors;

        function new();
            foreach (stk[i]) stk[i] = '0;
            foreach (vars[i]) vars[i] = '0;
            sp = 0;
            ip = 0;
            stopped = 0;
            cause = ST_RUN;
            prog_len = 0;
            errors = 0;
        endfunction

        function int unsigned eff_len();
            return (prog_len > PROGRAM_DEPTH) ? PROGRAM_DEPTH : prog_len;
        endfunction

        function bit [31:0] sdiv(bit [31:0] a, bit [31:0] b);
            bit [31:0] ma;
            bit [31:0] mb;
            bit [31:0] q;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        function void note_cmd(bit [4:0] op, bit [31:0] imm);
            int unsigned len;
            int unsigned nxt;
            int unsigned nsp;
            bit [31:0]   a;
            bit [31:0]   b;
            bit [31:0]   r;
            bit [2:0]    flt;
            bit          pv;
            bit [31:0]   pval;
            smc_result_t res;
            len = eff_len();
            nxt = ip + 1;
            nsp = sp;
            flt = ST_RUN;
            pv = 0;
            pval = '0;
            if (stopped) begin
                res = '{ip[ADDR_W-1:0], 1'b0, 32'd0, cause};
                pending.push_back(res);
                return;
            end
            if (ip >= len) begin
                ip = len;
                stopped = 1;
                cause = ST_END;
                res = '{len[ADDR_W-1:0], 1'b0, 32'd0, ST_END};
                pending.push_back(res);
                return;
            end
            case (op)
                OP_PUSH:
                    if (sp >= STACK_DEPTH) flt = ST_STACK;
                    else begin
                        stk[sp] = imm;
                        nsp = sp + 1;
                        nxt = ip + 2;
                    end
                OP_POP:
                    if (sp < 1) flt = ST_STACK;
                    else nsp = sp - 1;
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_GT:
                    if (sp < 2) flt = ST_STACK;
                    else begin
                        b = stk[sp-1];
                        a = stk[sp-2];
                        case (op)
                            OP_ADD: r = a + b;
                            OP_SUB: r = a - b;
                            OP_MUL: r = a * b;
                            OP_DIV: r = (b == 0) ? 32'd0 : sdiv(a, b);
                            OP_EQ:  r = (a == b);
                            OP_LT:  r = ($signed(a) < $signed(b));
                            default: r = ($signed(a) > $signed(b));
                        endcase
                        if (op == OP_DIV && b == 0) flt = ST_DIV0;
                        else begin
                            stk[sp-2] = r;
                            nsp = sp - 1;
                        end
                    end
                OP_DUP:
                    if (sp < 1 || sp >= STACK_DEPTH) flt = ST_STACK;
                    else begin
                        stk[sp] = stk[sp-1];
                        nsp = sp + 1;
                    end
                OP_SWAP:
                    if (sp < 2) flt = ST_STACK;
                    else begin
                        r = stk[sp-1];
                        stk[sp-1] = stk[sp-2];
                        stk[sp-2] = r;
                    end
                OP_PRINT:
                    if (sp < 1) flt = ST_STACK;
                    else begin
                        pv = 1;
                        pval = stk[sp-1];
                    end
                OP_JMP:
                    if (imm > len) flt = ST_INDEX;
                    else nxt = imm;
                OP_JZ, OP_JNZ:
                    if (sp < 1) flt = ST_STACK;
                    else begin
                        if ((stk[sp-1] == 0) == (op == OP_JZ)) begin
                            if (imm > len) flt = ST_INDEX;
                            else nxt = imm;
                        end
                        else nxt = ip + 2;
                        nsp = sp - 1;
                    end
                OP_ALLOC:
                    if (imm >= VAR_DEPTH) flt = ST_INDEX;
                    else begin
                        vars[imm] = '0;
                        nxt = ip + 2;
                    end
                OP_LOAD:
                    if (imm >= VAR_DEPTH) flt = ST_INDEX;
                    else if (sp >= STACK_DEPTH) flt = ST_STACK;
                    else begin
                        stk[sp] = vars[imm];
                        nsp = sp + 1;
                        nxt = ip + 2;
                    end
                OP_STORE:
                    if (imm >= VAR_DEPTH) flt = ST_INDEX;
                    else if (sp < 1) flt = ST_STACK;
                    else begin
                        nsp = sp - 1;
                        vars[imm] = stk[nsp];
                        nxt = ip + 2;
                    end
                OP_HALT: flt = ST_END;
                default: flt = ST_BADOP;
            endcase
            if (flt != ST_RUN) begin
                stopped = 1;
                cause = flt;
                res = '{ip[ADDR_W-1:0], 1'b0, 32'd0, flt};
                pending.push_back(res);
                return;
            end
            sp = nsp;
            if (nxt >= len) begin
                nxt = len;
                stopped = 1;
                cause = ST_END;
            end
            ip = nxt;
            res = '{nxt[ADDR_W-1:0], pv, pval, stopped ? ST_END : ST_RUN};
            pending.push_back(res);
        endfunction

        function void check_res(smc_result_t got);
            smc_result_t exp_res;
            if (pending.size() == 0) begin
                if (errors < 10)
                    $display("ERROR: unexpected result addr=%0d pv=%0b val=%h st=%0d",
                             got.addr, got.pv, got.val, got.st);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (got !== exp_res) begin
                if (errors < 10)
                    $display("ERROR: exp addr=%0d pv=%0b val=%h st=%0d, got addr=%0d pv=%0b val=%h st=%0d",
                             exp_res.addr, exp_res.pv, exp_res.val, exp_res.st,
                             got.addr, got.pv, got.val, got.st);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [ADDR_W-1:0]        cfg_data;
    logic                     cmd_valid;
    logic                     cmd_stall;
    logic [4:0]               opcode;
    logic signed [DATA_W-1:0] immediate;
    logic                     res_valid;
    logic                     res_stall;
    logic [ADDR_W-1:0]        next_address;
    logic                     print_valid;
    logic signed [DATA_W-1:0] print_value;
    logic [2:0]               status;

    smc_scoreboard sb;
    bit            quiet;
    int unsigned   cycles;

    stack_machine_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .opcode       (opcode),
        .immediate    (immediate),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .next_address (next_address),
        .print_valid  (print_valid),
        .print_value  (print_value),
        .status       (status)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        res_stall <= !quiet && ($urandom_range(0, 99) < 11);
        if (rst_n && res_valid && !res_stall)
            sb.check_res('{next_address, print_valid, print_value, status});
    end

    task automatic send_cmd(input logic [4:0] op, input logic [31:0] imm);
        while (!quiet && $urandom_range(0, 99) < 11)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        opcode    <= op;
        immediate <= imm;
        do
            @(posedge clk);
        while (cmd_stall);
        sb.note_cmd(op, imm);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_len(input int unsigned v);
        cfg_write <= 1'b1;
        cfg_data  <= v[ADDR_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.prog_len = v & 32'h1FFF;
    endtask

    function automatic bit op_ok(bit [4:0] op);
        int unsigned s;
        s = sb.sp;
        case (op)
            OP_PUSH, OP_LOAD:                    return s < 100;
            OP_DUP:                              return s >= 1 && s < 100;
            OP_POP, OP_PRINT, OP_STORE, OP_JZ, OP_JNZ: return s >= 1;
            OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_LT, OP_GT, OP_SWAP: return s >= 2;
            OP_DIV:                              return s >= 2 && sb.stk[s-1] != 0;
            OP_JMP, OP_ALLOC:                    return 1;
            default:                             return 0;
        endcase
    endfunction

    task automatic gen_item(output logic [4:0] op, output logic [31:0] imm);
        int unsigned len;
        int unsigned tmax;
        len = sb.eff_len();
        tmax = (len - 4 < 63) ? len - 4 : 63;
        if (sb.ip + 3 >= len)
            op = OP_JMP;
        else
            do
                op = ($urandom_range(0, 99) < 20) ? 5'(OP_PUSH) : 5'($urandom_range(0, 17));
            while (!op_ok(op));
        case (op)
            OP_PUSH:
                case ($urandom_range(0, 3))
                    0: imm = $urandom;
                    1: imm = 32'd0;
                    2: imm = $urandom_range(0, 6) - 3;
                    default: imm = ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                endcase
            OP_JMP, OP_JZ, OP_JNZ:       imm = $urandom_range(0, tmax);
            OP_ALLOC, OP_LOAD, OP_STORE: imm = $urandom_range(0, VAR_DEPTH - 1);
            default:                     imm = $urandom;
        endcase
    endtask

    task automatic run_directed();
        send_cmd(OP_PUSH, 32'h7FFF_FFFF);
        send_cmd(OP_PUSH, 32'h8000_0000);
        send_cmd(OP_PUSH, 32'hFFFF_FFFF);
        send_cmd(OP_DUP, 32'h0);
        send_cmd(OP_SWAP, 32'h0);
        send_cmd(OP_ADD, 32'h0);
        send_cmd(OP_SUB, 32'h0);
        send_cmd(OP_MUL, 32'h0);
        send_cmd(OP_PUSH, 32'h8000_0000);
        send_cmd(OP_PUSH, 32'hFFFF_FFFF);
        send_cmd(OP_DIV, 32'h0);
        send_cmd(OP_PRINT, 32'h0);
        send_cmd(OP_PUSH, 32'd7);
        send_cmd(OP_PUSH, 32'hFFFF_FFFE);
        send_cmd(OP_DIV, 32'h0);
        send_cmd(OP_LT, 32'h0);
        send_cmd(OP_GT, 32'h0);
        send_cmd(OP_PUSH, 32'd5);
        send_cmd(OP_EQ, 32'h0);
        send_cmd(OP_ALLOC, 32'd127);
        send_cmd(OP_LOAD, 32'd127);
        send_cmd(OP_STORE, 32'd0);
        send_cmd(OP_LOAD, 32'd0);
        send_cmd(OP_PUSH, 32'd0);
        send_cmd(OP_JZ, 32'd40);
        send_cmd(OP_PUSH, 32'd0);
        send_cmd(OP_JNZ, 32'd2);
        send_cmd(OP_JMP, 32'd0);
        send_cmd(OP_POP, 32'h0);
        send_cmd(OP_PRINT, 32'h0);
    endtask

    task automatic run_ending();
        logic [4:0]  op;
        logic [31:0] imm;
        case ($urandom_range(0, 8))
            0: send_cmd(OP_HALT, $urandom);
            1: send_cmd(5'($urandom_range(19, 31)), $urandom);
            2: repeat (sb.sp + 1) send_cmd(OP_POP, 32'h0);
            3:
            begin
                send_cmd(OP_PUSH, $urandom);
                send_cmd(OP_PUSH, 32'd0);
                send_cmd(OP_DIV, 32'h0);
            end
            4: send_cmd(OP_LOAD, ($urandom_range(0, 1)) ? $urandom | 32'h8000_0000
                                                         : $urandom_range(VAR_DEPTH, 4096));
            5: send_cmd(OP_JMP, ($urandom_range(0, 1)) ? $urandom | 32'h8000_0000
                                                        : sb.eff_len() + 1);
            6:
            begin
                write_len(4096);
                repeat (STACK_DEPTH - sb.sp + 1) send_cmd(OP_PUSH, $urandom);
            end
            7:
            begin
                write_len(0);
                send_cmd(OP_PUSH, $urandom);
            end
            default: send_cmd(OP_JMP, sb.eff_len());
        endcase
        repeat (10)
        begin
            gen_item(op, imm);
            send_cmd(op, imm);
        end
    endtask

    initial
    begin
        logic [4:0]  op;
        logic [31:0] imm;
        int unsigned lo;
        sb = new();
        quiet = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        cmd_valid = 1'b0;
        opcode = '0;
        immediate = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_len(8191);
        run_directed();
        for (int n = 0; n < ITEMS; n++)
        begin
            if (n % 230 == 0)
            begin
                drain();
                lo = (sb.ip + 8 > 16) ? sb.ip + 8 : 16;
                case ($urandom_range(0, 3))
                    0: write_len(4096);
                    1: write_len($urandom_range(4097, 8191));
                    2: write_len($urandom_range(lo, lo + 40));
                    default: write_len($urandom_range(lo, 4095));
                endcase
            end
            quiet = (n >= 500 && n < 700);
            gen_item(op, imm);
            send_cmd(op, imm);
        end
        quiet = 0;
        drain();
        run_ending();
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/smc_pkg.sv
src/smc_ram.sv
src/smc_div.sv
src/stack_machine_core.sv
dv/stack_machine_core_tb.sv
